// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rat_pkg.sv -----
package rat_pkg;

    localparam int TIME_WIDTH   = 32;
    localparam int PERIOD_WIDTH = 8;
    localparam int STEP_CNT_W   = $clog2(TIME_WIDTH + 1);

    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef logic [TIME_WIDTH-1:0]   tick_t;
    typedef logic [PERIOD_WIDTH-1:0] period_t;

    typedef struct packed {
        logic    start;
        tick_t   dividend;
        period_t divisor;
    } rem_req_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_rsp_t;

endpackage

// ----- design/rat_rem_unit.sv -----
module rat_rem_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  rat_pkg::rem_req_t req,
    output rat_pkg::rem_rsp_t rsp
);
    import rat_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    tick_t                 shift_reg;
    period_t               rem_reg;
    period_t               div_reg;

    logic [PERIOD_WIDTH:0] partial;
    logic                  take;
    period_t               rem_next;

    always_comb
    begin
        partial  = {rem_reg, shift_reg[TIME_WIDTH-1]};
        take     = (partial >= {1'b0, div_reg});
        rem_next = take ? PERIOD_WIDTH'(partial - {1'b0, div_reg})
                        : PERIOD_WIDTH'(partial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            shift_reg <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= STEP_CNT_W'(TIME_WIDTH);
                shift_reg <= req.dividend;
                rem_reg   <= '0;
                div_reg   <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg   <= rem_next;
                shift_reg <= {shift_reg[TIME_WIDTH-2:0], 1'b0};
                cnt_reg   <= cnt_reg - STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

endmodule

// ----- design/recurring_alarm_timer_core.sv -----
// Recurring alarm checked against a free-running tick count. Each command
// transaction returns exactly one response transaction. A start command
// passes from idle to the finish state. A check command passes through the
// evaluate and finish states when the period is zero or the difference is
// negative, zero or below twice the period. It also passes through the
// division state when the remainder of the difference by the period is
// needed, where a single subtract-and-compare unit produces one remainder
// bit per cycle. A stalled response holds the finish state until the
// response register is free. The block takes one command at a time; the
// response register lets the next command enter while a response still
// waits to be taken. The period register is written through its own port,
// which is always ready; the user must write it only while the block is
// idle, which the block itself does not enforce.
`include "assert_macros.svh"

module recurring_alarm_timer_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  logic                      opcode,
    input  rat_pkg::tick_t            now,
    input  rat_pkg::tick_t            offset,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic                      fire,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  rat_pkg::period_t          period
);
    import rat_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_FIN
    } state_t;

    state_t   state_reg;
    period_t  period_reg;
    tick_t    anchor_reg;
    tick_t    now_reg;
    tick_t    diff_reg;
    logic     fire_pend_reg;
    logic     upd_reg;
    logic     rsp_valid_reg;
    logic     fire_reg;

    rem_req_t rem_req;
    rem_rsp_t rem_rsp;

    logic     cmd_accept;
    logic     out_free;
    logic     fin_load;
    tick_t    period_ext;
    tick_t    twice_ext;
    logic     need_div;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign cfg_ready  = 1'b1;
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign fin_load   = (state_reg == S_FIN) && out_free;

    always_comb
    begin
        period_ext = TIME_WIDTH'(period_reg);
        twice_ext  = TIME_WIDTH'({period_reg, 1'b0});
        need_div   = (period_reg != '0) && !diff_reg[TIME_WIDTH-1]
                     && (diff_reg != '0) && (diff_reg >= twice_ext);
    end

    assign rem_req.start    = (state_reg == S_EVAL) && need_div;
    assign rem_req.dividend = diff_reg;
    assign rem_req.divisor  = period_reg;

    rat_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            period_reg    <= '0;
            anchor_reg    <= '0;
            now_reg       <= '0;
            diff_reg      <= '0;
            fire_pend_reg <= 1'b0;
            upd_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            fire_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= period;
            end

            if (rsp_valid_reg && !rsp_stall && !fin_load)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_accept)
                    begin
                        if (opcode == OP_START)
                        begin
                            anchor_reg    <= now + offset;
                            fire_pend_reg <= 1'b0;
                            upd_reg       <= 1'b0;
                            state_reg     <= S_FIN;
                        end
                        else
                        begin
                            now_reg   <= now;
                            diff_reg  <= now - anchor_reg;
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_EVAL:
                begin
                    priority if (period_reg == '0 || diff_reg[TIME_WIDTH-1])
                    begin
                        fire_pend_reg <= 1'b0;
                        upd_reg       <= 1'b0;
                        state_reg     <= S_FIN;
                    end
                    else if (diff_reg == '0)
                    begin
                        fire_pend_reg <= 1'b1;
                        upd_reg       <= 1'b0;
                        state_reg     <= S_FIN;
                    end
                    else if (diff_reg < period_ext)
                    begin
                        fire_pend_reg <= 1'b0;
                        upd_reg       <= 1'b0;
                        state_reg     <= S_FIN;
                    end
                    else if (diff_reg < twice_ext)
                    begin
                        fire_pend_reg <= 1'b1;
                        upd_reg       <= 1'b1;
                        state_reg     <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (rem_rsp.done)
                    begin
                        fire_pend_reg <= rem_rsp.zero;
                        upd_reg       <= rem_rsp.zero;
                        state_reg     <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        fire_reg      <= fire_pend_reg;
                        if (upd_reg)
                        begin
                            anchor_reg <= now_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign fire      = fire_reg;

    `ASSERT_IMPLIES(a_rem_done_in_div, clk, rst_n, rem_rsp.done, state_reg == S_DIV,
        "remainder unit finished outside the division state")
    `ASSERT_IMPLIES(a_div_only_valid, clk, rst_n, rem_req.start,
        (period_reg != '0) && !diff_reg[TIME_WIDTH-1],
        "remainder started with zero period or negative difference")
    `ASSERT_IMPLIES(a_reanchor_fires, clk, rst_n, (state_reg == S_FIN) && upd_reg,
        fire_pend_reg, "re-anchor requested without a fire")
    `ASSERT_NEXT(a_anchor_stable, clk, rst_n, !cmd_accept && !(fin_load && upd_reg),
        $stable(anchor_reg), "anchor changed without a start or a re-anchor")

endmodule
